### design/sftt_pkg.sv
// shared types, constants and codes of the sparse triple transpose core
// no dependencies; every other design file but sftt_ram imports this package
package sftt_pkg;

	// capacity and field widths
	localparam int MAX_ENTRIES = 64;
	localparam int MAX_DIM     = 256;
	localparam int VALUE_WIDTH = 32;
	localparam int IDX_W       = 9;
	localparam int ENT_AW      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

	// one bucket per column code, bucket zero is the out-of-range tail
	localparam int BKT_AW    = IDX_W;
	localparam int BKT_DEPTH = 1 << BKT_AW;
	localparam int BKT_CW    = BKT_AW + 1;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = IDX_W;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = CFG_IDX_W'(1);

	// one stored triple
	typedef struct packed {
		logic [IDX_W-1:0]       row;
		logic [IDX_W-1:0]       col;
		logic [VALUE_WIDTH-1:0] value;
	} entry_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_LOAD,
		ST_CNT_RD,
		ST_CNT_BKT,
		ST_CNT_WR,
		ST_PRE_RD,
		ST_PRE_WR,
		ST_SCT_RD,
		ST_SCT_BKT,
		ST_SCT_WR,
		ST_EMIT_RD,
		ST_EMIT_LOAD,
		ST_EMIT_WAIT
	} state_t;

	// shared adder operations
	typedef enum logic {
		ALU_INC,
		ALU_ADD
	} alu_op_t;

	// port request to an entry store
	typedef struct packed {
		logic              we;
		logic [ENT_AW-1:0] waddr;
		entry_t            wdata;
		logic              re;
		logic [ENT_AW-1:0] raddr;
	} ent_req_t;

	// port request to a bucket memory
	typedef struct packed {
		logic              we;
		logic [BKT_AW-1:0] waddr;
		logic [CNT_W-1:0]  wdata;
		logic              re;
		logic [BKT_AW-1:0] raddr;
	} bkt_req_t;

	// sequencer to handshake logic
	typedef struct packed {
		logic in_ready;
		logic out_load;
		logic out_last;
		logic overflow;
	} ctl_t;

endpackage

### design/sftt_ram.sv
// generic simple dual-port memory, one write and one registered read a cycle
// no package dependencies
module sftt_ram #(
	parameter int DATA_W = 8,
	parameter int ADDR_W = 4
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [1 << ADDR_W];
	logic [DATA_W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### design/sftt_alu.sv
// shared unit: bucket select by column range compare, and the one adder
// used for counting, prefix sum and position bump; depends on sftt_pkg
module sftt_alu (
	input  sftt_pkg::alu_op_t            op,
	input  logic [sftt_pkg::CNT_W-1:0]   a,
	input  logic [sftt_pkg::CNT_W-1:0]   b,
	input  logic [sftt_pkg::IDX_W-1:0]   col,
	input  logic [sftt_pkg::IDX_W-1:0]   num_cols,
	output logic [sftt_pkg::CNT_W-1:0]   sum,
	output logic [sftt_pkg::BKT_AW-1:0]  bucket
);
	import sftt_pkg::*;

	logic [CNT_W-1:0] addend;

	// second operand: one for a bump, b for a running sum
	always_comb begin
		unique case (op)
			ALU_INC: addend = CNT_W'(1);
			ALU_ADD: addend = b;
		endcase
	end

	assign sum = a + addend;

	// columns outside 1..num_cols share the tail bucket
	assign bucket = ((col != '0) && (col <= num_cols)) ? BKT_AW'(col) : '0;

endmodule

### design/sftt_ctrl.sv
// sequencer of clear, load, count, prefix, scatter and emit passes
// depends on sftt_pkg and sftt_alu
module sftt_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [sftt_pkg::IDX_W-1:0] num_cols,
	input  logic                       in_acc,
	input  logic                       in_last,
	input  sftt_pkg::entry_t           in_entry,
	input  logic                       out_done,
	input  sftt_pkg::entry_t           tst_rdata,
	input  logic [sftt_pkg::CNT_W-1:0] cnt_rdata,
	input  logic [sftt_pkg::CNT_W-1:0] np_rdata,
	output sftt_pkg::ent_req_t         tst_req,
	output sftt_pkg::ent_req_t         ost_req,
	output sftt_pkg::bkt_req_t         cnt_req,
	output sftt_pkg::bkt_req_t         np_req,
	output sftt_pkg::ctl_t             ctl
);
	import sftt_pkg::*;

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic              drop_q;
	logic [CNT_W-1:0]  ent_idx_q;
	logic [BKT_CW-1:0] bkt_idx_q;
	logic [CNT_W-1:0]  pos_q;
	logic [BKT_AW-1:0] bkt_q;

	logic [CNT_W-1:0]  ent_next;
	logic              ent_end;
	logic              cnt_full;
	logic              clear_end;
	logic              pre_end;
	logic [BKT_AW-1:0] bkt_addr;

	alu_op_t           alu_op;
	logic [CNT_W-1:0]  alu_a;
	logic [CNT_W-1:0]  alu_b;
	logic [CNT_W-1:0]  alu_sum;
	logic [BKT_AW-1:0] alu_bucket;

	// loop bounds
	assign ent_next  = ent_idx_q + CNT_W'(1);
	assign ent_end   = (ent_next == cnt_q);
	assign cnt_full  = (cnt_q == CNT_W'(MAX_ENTRIES));
	assign clear_end = (bkt_idx_q == BKT_CW'(BKT_DEPTH - 1));
	assign pre_end   = (bkt_idx_q == BKT_CW'(BKT_DEPTH));
	// prefix runs 1..depth-1 and wraps to the tail bucket last
	assign bkt_addr  = bkt_idx_q[BKT_AW-1:0];

	sftt_alu u_alu (
		.op       (alu_op),
		.a        (alu_a),
		.b        (alu_b),
		.col      (tst_rdata.col),
		.num_cols (num_cols),
		.sum      (alu_sum),
		.bucket   (alu_bucket)
	);

	// operand select for the shared adder
	always_comb begin
		alu_op = ALU_INC;
		alu_a  = cnt_rdata;
		alu_b  = cnt_rdata;
		unique case (state_q)
			ST_PRE_WR: begin
				alu_op = ALU_ADD;
				alu_a  = pos_q;
			end
			ST_SCT_WR: begin
				alu_a = np_rdata;
			end
			default: begin
				alu_op = ALU_INC;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:     if (clear_end) state_d = ST_LOAD;
			ST_LOAD:      if (in_acc && in_last) state_d = ST_CNT_RD;
			ST_CNT_RD:    state_d = ST_CNT_BKT;
			ST_CNT_BKT:   state_d = ST_CNT_WR;
			ST_CNT_WR:    state_d = ent_end ? ST_PRE_RD : ST_CNT_RD;
			ST_PRE_RD:    state_d = ST_PRE_WR;
			ST_PRE_WR:    state_d = pre_end ? ST_SCT_RD : ST_PRE_RD;
			ST_SCT_RD:    state_d = ST_SCT_BKT;
			ST_SCT_BKT:   state_d = ST_SCT_WR;
			ST_SCT_WR:    state_d = ent_end ? ST_EMIT_RD : ST_SCT_RD;
			ST_EMIT_RD:   state_d = ST_EMIT_LOAD;
			ST_EMIT_LOAD: state_d = ST_EMIT_WAIT;
			ST_EMIT_WAIT: if (out_done) state_d = ent_end ? ST_LOAD : ST_EMIT_RD;
			default:      state_d = ST_CLEAR;
		endcase
	end

	// memory requests and handshake controls
	always_comb begin
		tst_req = '0;
		ost_req = '0;
		cnt_req = '0;
		np_req  = '0;
		ctl     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cnt_req.we    = 1'b1;
				cnt_req.waddr = bkt_addr;
				cnt_req.wdata = '0;
			end
			ST_LOAD: begin
				ctl.in_ready  = 1'b1;
				tst_req.we    = in_acc && !cnt_full;
				tst_req.waddr = cnt_q[ENT_AW-1:0];
				tst_req.wdata = in_entry;
			end
			ST_CNT_RD, ST_SCT_RD: begin
				tst_req.re    = 1'b1;
				tst_req.raddr = ent_idx_q[ENT_AW-1:0];
			end
			ST_CNT_BKT: begin
				cnt_req.re    = 1'b1;
				cnt_req.raddr = alu_bucket;
			end
			ST_CNT_WR: begin
				cnt_req.we    = 1'b1;
				cnt_req.waddr = bkt_q;
				cnt_req.wdata = alu_sum;
			end
			ST_PRE_RD: begin
				cnt_req.re    = 1'b1;
				cnt_req.raddr = bkt_addr;
			end
			ST_PRE_WR: begin
				// start position out, counter cleared for the next matrix
				np_req.we     = 1'b1;
				np_req.waddr  = bkt_addr;
				np_req.wdata  = pos_q;
				cnt_req.we    = 1'b1;
				cnt_req.waddr = bkt_addr;
				cnt_req.wdata = '0;
			end
			ST_SCT_BKT: begin
				np_req.re    = 1'b1;
				np_req.raddr = alu_bucket;
			end
			ST_SCT_WR: begin
				ost_req.we    = 1'b1;
				ost_req.waddr = np_rdata[ENT_AW-1:0];
				ost_req.wdata = tst_rdata;
				np_req.we     = 1'b1;
				np_req.waddr  = bkt_q;
				np_req.wdata  = alu_sum;
			end
			ST_EMIT_RD: begin
				ost_req.re    = 1'b1;
				ost_req.raddr = ent_idx_q[ENT_AW-1:0];
			end
			ST_EMIT_LOAD: begin
				ctl.out_load = 1'b1;
				ctl.out_last = ent_end;
				ctl.overflow = drop_q;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			cnt_q     <= '0;
			drop_q    <= 1'b0;
			ent_idx_q <= '0;
			bkt_idx_q <= '0;
			pos_q     <= '0;
			bkt_q     <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_CLEAR: begin
					bkt_idx_q <= bkt_idx_q + BKT_CW'(1);
				end
				ST_LOAD: begin
					if (in_acc) begin
						if (cnt_full) begin
							drop_q <= 1'b1;
						end else begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
						if (in_last) begin
							ent_idx_q <= '0;
						end
					end
				end
				ST_CNT_BKT, ST_SCT_BKT: begin
					bkt_q <= alu_bucket;
				end
				ST_CNT_WR: begin
					if (ent_end) begin
						bkt_idx_q <= BKT_CW'(1);
						pos_q     <= '0;
					end else begin
						ent_idx_q <= ent_next;
					end
				end
				ST_PRE_WR: begin
					pos_q <= alu_sum;
					if (pre_end) begin
						ent_idx_q <= '0;
					end else begin
						bkt_idx_q <= bkt_idx_q + BKT_CW'(1);
					end
				end
				ST_SCT_WR: begin
					ent_idx_q <= ent_end ? '0 : ent_next;
				end
				ST_EMIT_WAIT: begin
					if (out_done) begin
						if (ent_end) begin
							cnt_q  <= '0;
							drop_q <= 1'b0;
						end else begin
							ent_idx_q <= ent_next;
						end
					end
				end
				default: begin
					pos_q <= pos_q;
				end
			endcase
		end
	end

endmodule

### design/sparse_triple_fast_transpose_core.sv
// Sparse transpose core: loads triples, one request a cycle, until the marked last one.
// Then over the held entries: counting, a prefix pass over the column counter memory,
// scatter, then each result through the output register, the next read only once the last is taken.
// Rate is set by the single shared adder and one access per memory port per cycle.
// Reset is asynchronous, active low; after it a pass clears the column counters
// and no input is taken meanwhile (configuration writes are taken throughout).
module sparse_triple_fast_transpose_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [sftt_pkg::IDX_W-1:0]           in_row,
	input  logic [sftt_pkg::IDX_W-1:0]           in_col,
	input  logic signed [sftt_pkg::VALUE_WIDTH-1:0] in_value,
	input  logic                                 in_last,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [sftt_pkg::IDX_W-1:0]           out_row,
	output logic [sftt_pkg::IDX_W-1:0]           out_col,
	output logic signed [sftt_pkg::VALUE_WIDTH-1:0] out_value,
	output logic                                 out_last,
	output logic                                 overflow,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [sftt_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sftt_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import sftt_pkg::*;

	logic [IDX_W-1:0]       num_cols_q;
	logic                   in_acc;
	logic                   out_done;
	entry_t                 in_entry;
	entry_t                 tst_rdata;
	entry_t                 ost_rdata;
	logic [CNT_W-1:0]       cnt_rdata;
	logic [CNT_W-1:0]       np_rdata;
	ent_req_t               tst_req;
	ent_req_t               ost_req;
	bkt_req_t               cnt_req;
	bkt_req_t               np_req;
	ctl_t                   ctl;

	logic                   out_valid_q;
	logic [IDX_W-1:0]       out_row_q;
	logic [IDX_W-1:0]       out_col_q;
	logic [VALUE_WIDTH-1:0] out_value_q;
	logic                   out_last_q;
	logic                   overflow_q;

	// configuration registers; the row count does not affect ordering
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_cols_q <= IDX_W'(MAX_DIM);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_NUM_ROWS: num_cols_q <= num_cols_q;
				REG_NUM_COLS: num_cols_q <= cfg_data;
				default:      num_cols_q <= num_cols_q;
			endcase
		end
	end

	// input request
	assign in_stall = !ctl.in_ready;
	assign in_acc   = in_valid && ctl.in_ready;
	assign in_entry = '{row: in_row, col: in_col, value: in_value};

	sftt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.num_cols  (num_cols_q),
		.in_acc    (in_acc),
		.in_last   (in_last),
		.in_entry  (in_entry),
		.out_done  (out_done),
		.tst_rdata (tst_rdata),
		.cnt_rdata (cnt_rdata),
		.np_rdata  (np_rdata),
		.tst_req   (tst_req),
		.ost_req   (ost_req),
		.cnt_req   (cnt_req),
		.np_req    (np_req),
		.ctl       (ctl)
	);

	// loaded triples in arrival order
	sftt_ram #(.DATA_W($bits(entry_t)), .ADDR_W(ENT_AW)) u_triple_store (
		.clk   (clk),
		.we    (tst_req.we),
		.waddr (tst_req.waddr),
		.wdata (tst_req.wdata),
		.re    (tst_req.re),
		.raddr (tst_req.raddr),
		.rdata (tst_rdata)
	);

	// triples in transposed order
	sftt_ram #(.DATA_W($bits(entry_t)), .ADDR_W(ENT_AW)) u_out_store (
		.clk   (clk),
		.we    (ost_req.we),
		.waddr (ost_req.waddr),
		.wdata (ost_req.wdata),
		.re    (ost_req.re),
		.raddr (ost_req.raddr),
		.rdata (ost_rdata)
	);

	// per-column entry counters
	sftt_ram #(.DATA_W(CNT_W), .ADDR_W(BKT_AW)) u_column_count (
		.clk   (clk),
		.we    (cnt_req.we),
		.waddr (cnt_req.waddr),
		.wdata (cnt_req.wdata),
		.re    (cnt_req.re),
		.raddr (cnt_req.raddr),
		.rdata (cnt_rdata)
	);

	// per-column next write position
	sftt_ram #(.DATA_W(CNT_W), .ADDR_W(BKT_AW)) u_column_next_pos (
		.clk   (clk),
		.we    (np_req.we),
		.waddr (np_req.waddr),
		.wdata (np_req.wdata),
		.re    (np_req.re),
		.raddr (np_req.raddr),
		.rdata (np_rdata)
	);

	// output register, old column becomes row
	assign out_done = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_done) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			out_row_q   <= ost_rdata.col;
			out_col_q   <= ost_rdata.row;
			out_value_q <= ost_rdata.value;
			out_last_q  <= ctl.out_last;
			overflow_q  <= ctl.overflow;
		end
	end

	assign out_valid = out_valid_q;
	assign out_row   = out_row_q;
	assign out_col   = out_col_q;
	assign out_value = $signed(out_value_q);
	assign out_last  = out_last_q;
	assign overflow  = overflow_q;

endmodule
